### hdl/pwmt_pkg.sv
package pwmt_pkg;

  // field widths
  localparam int unsigned WidthW = 21;
  localparam int unsigned TicksW = 24;
  localparam int unsigned CountW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  localparam int unsigned TICKS_PER_UNIT_DEF = 8;

  localparam logic [WidthW-1:0] WIDTH_MAX = {WidthW{1'b1}};
  localparam logic [WidthW-1:0] FULL_SCALE = WidthW'(40000);
  localparam logic [WidthW-1:0] MID_TIMEOUT_WIDTH = WidthW'(1);
  localparam logic [TicksW-1:0] TICKS_MAX = {TicksW{1'b1}};

  localparam logic [TicksW-1:0] TIMEOUT_RESET = TicksW'(448000);
  localparam logic ACTIVE_LEVEL_RESET = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_LEVEL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 2'd1;

  // request commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_START = 1'b1;

  typedef enum logic [1:0] {
    OUTCOME_VALID = 2'd0,
    OUTCOME_STUCK_ACTIVE = 2'd1,
    OUTCOME_STUCK_INACTIVE = 2'd2,
    OUTCOME_END_TIMEOUT = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [WidthW-1:0] pulse_width;
    outcome_e outcome;
    logic [CountW-1:0] measure_count;
    logic [CountW-1:0] measure_ticks;
    logic [CountW-1:0] max_measure_ticks;
  } result_t;

endpackage

### hdl/pulse_width_meter_timeout.sv
// channel  | signals                                   | direction
// in       | in_valid_i, in_stall_o, cmd_i, pin_level_i | request in
// out      | out_valid_o, out_stall_i, result fields    | result out
// cfg      | cfg_valid_i, cfg_ready_o, index, data      | register write
//
// one request per cycle unless stalled; a tick request that completes a
// measurement registers its result in the output register, or in a second (skid)
// register if that is still held; the input stalls only while the skid is full
// asynchronous active-low reset returns to idle, clears counters and loads
// active level 1 and a timeout of 448000 ticks
module pulse_width_meter_timeout
  import pwmt_pkg::*;
#(
  parameter int unsigned TicksPerUnit = TICKS_PER_UNIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic                pin_level_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [WidthW-1:0]   pulse_width_o,
  output logic [1:0]          outcome_o,
  output logic [CountW-1:0]   measure_count_o,
  output logic [CountW-1:0]   measure_ticks_o,
  output logic [CountW-1:0]   max_measure_ticks_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned RemW = (TicksPerUnit > 1) ? $clog2(TicksPerUnit) : 1;
  localparam logic [RemW-1:0] RemLast = RemW'(TicksPerUnit - 1);
  localparam logic [TicksW-1:0] UnitsInit = (TicksPerUnit == 1) ? TicksW'(1) : '0;
  localparam logic [RemW-1:0] RemInit = (TicksPerUnit == 1) ? '0 : RemW'(1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEAVE = 2'd1;
  localparam logic [1:0] PH_WAIT = 2'd2;
  localparam logic [1:0] PH_COUNT = 2'd3;

  logic              active_level_q;
  logic [TicksW-1:0] timeout_q;

  logic [1:0]        phase_q, phase_d;
  logic [TicksW-1:0] elapsed_q, elapsed_d;
  logic [TicksW-1:0] act_q, act_d;
  // active ticks kept as units and a remainder, so no divider is needed
  logic [TicksW-1:0] units_q, units_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [CountW-1:0] total_q, total_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] max_q, max_d;

  logic              accept;
  logic              active;
  logic [TicksW-1:0] elapsed_inc;
  logic [CountW-1:0] total_inc;
  logic              fin;
  logic [WidthW-1:0] fin_width;
  outcome_e          fin_outcome;
  logic [WidthW-1:0] width_sat;
  result_t           res;

  logic              main_valid_q, skid_valid_q;
  result_t           main_q, skid_q;
  logic              pop;

  assign in_stall_o = skid_valid_q;
  assign accept = in_valid_i & ~in_stall_o;
  assign active = (pin_level_i == active_level_q);
  assign elapsed_inc = elapsed_q + TicksW'(1);
  assign total_inc = total_q + CountW'(1);
  assign width_sat = (units_q > TicksW'(WIDTH_MAX)) ? WIDTH_MAX : units_q[WidthW-1:0];

  always_comb begin
    phase_d = phase_q;
    elapsed_d = elapsed_q;
    act_d = act_q;
    units_d = units_q;
    rem_d = rem_q;
    total_d = total_q;
    count_d = count_q;
    max_d = max_q;
    fin = 1'b0;
    fin_width = FULL_SCALE;
    fin_outcome = OUTCOME_VALID;
    if (accept) begin
      if (cmd_i == CMD_START) begin
        if (phase_q == PH_IDLE) begin
          phase_d = PH_LEAVE;
          elapsed_d = '0;
          act_d = '0;
          units_d = '0;
          rem_d = '0;
          total_d = '0;
        end
      end else if (phase_q != PH_IDLE) begin
        total_d = total_inc;
        unique case (phase_q)
          PH_LEAVE: begin
            if (!active) begin
              phase_d = PH_WAIT;
              elapsed_d = '0;
            end else begin
              elapsed_d = elapsed_inc;
              if (elapsed_inc >= timeout_q) begin
                fin = 1'b1;
                fin_width = FULL_SCALE;
                fin_outcome = OUTCOME_STUCK_ACTIVE;
              end
            end
          end
          PH_WAIT: begin
            if (active) begin
              phase_d = PH_COUNT;
              elapsed_d = '0;
              act_d = TicksW'(1);
              units_d = UnitsInit;
              rem_d = RemInit;
            end else begin
              elapsed_d = elapsed_inc;
              if (elapsed_inc >= timeout_q) begin
                fin = 1'b1;
                fin_width = MID_TIMEOUT_WIDTH;
                fin_outcome = OUTCOME_STUCK_INACTIVE;
              end
            end
          end
          PH_COUNT: begin
            if (!active) begin
              fin = 1'b1;
              fin_width = width_sat;
              fin_outcome = OUTCOME_VALID;
            end else begin
              if (act_q != TICKS_MAX) begin
                act_d = act_q + TicksW'(1);
                if (rem_q == RemLast) begin
                  rem_d = '0;
                  units_d = units_q + TicksW'(1);
                end else begin
                  rem_d = rem_q + RemW'(1);
                end
              end
              elapsed_d = elapsed_inc;
              if (elapsed_inc >= timeout_q) begin
                fin = 1'b1;
                fin_width = FULL_SCALE;
                fin_outcome = OUTCOME_END_TIMEOUT;
              end
            end
          end
          default: begin
            phase_d = phase_q;
          end
        endcase
        if (fin) begin
          phase_d = PH_IDLE;
          count_d = count_q + CountW'(1);
          max_d = (max_q < total_inc) ? total_inc : max_q;
        end
      end
    end
  end

  always_comb begin
    res.pulse_width = fin_width;
    res.outcome = fin_outcome;
    res.measure_count = count_d;
    res.measure_ticks = total_inc;
    res.max_measure_ticks = max_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q <= ACTIVE_LEVEL_RESET;
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_ACTIVE_LEVEL) begin
        active_level_q <= cfg_data_i[0];
      end else if (cfg_index_i == REG_TIMEOUT_TICKS) begin
        timeout_q <= cfg_data_i[TicksW-1:0];
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      elapsed_q <= '0;
      act_q <= '0;
      units_q <= '0;
      rem_q <= '0;
      total_q <= '0;
      count_q <= '0;
      max_q <= '0;
    end else begin
      phase_q <= phase_d;
      elapsed_q <= elapsed_d;
      act_q <= act_d;
      units_q <= units_d;
      rem_q <= rem_d;
      total_q <= total_d;
      count_q <= count_d;
      max_q <= max_d;
    end
  end

  // output register with skid; a new result never meets a full skid
  assign pop = main_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop || !main_valid_q) begin
        main_valid_q <= skid_valid_q | fin;
        skid_valid_q <= 1'b0;
      end else if (fin) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !main_valid_q) begin
      main_q <= skid_valid_q ? skid_q : res;
    end else if (fin) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = main_valid_q;
  assign pulse_width_o = main_q.pulse_width;
  assign outcome_o = main_q.outcome;
  assign measure_count_o = main_q.measure_count;
  assign measure_ticks_o = main_q.measure_ticks;
  assign max_measure_ticks_o = main_q.max_measure_ticks;

endmodule

### bench/tb_top.sv
module tb_top
  import pwmt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 5000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned RequestBudget = 1600;
  localparam int unsigned PhaseCount = 8;

  // indexes that decode to no register
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAVE,
    PH_WAIT,
    PH_COUNT
  } meter_phase_e;

  class meter_scoreboard;
    logic              active_level;
    logic [TicksW-1:0] timeout_ticks;
    meter_phase_e      phase;
    logic [TicksW-1:0] phase_elapsed;
    logic [TicksW-1:0] active_ticks;
    logic [CountW-1:0] total_elapsed;
    logic [CountW-1:0] completed;
    logic [CountW-1:0] longest;
    result_t           measurements_due[$];
    int unsigned       errors;
    int unsigned       timeouts;
    int unsigned       seen;

    function new();
      active_level = ACTIVE_LEVEL_RESET;
      timeout_ticks = TIMEOUT_RESET;
      phase = PH_IDLE;
      phase_elapsed = '0;
      active_ticks = '0;
      total_elapsed = '0;
      completed = '0;
      longest = '0;
      errors = 0;
      timeouts = 0;
      seen = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == REG_ACTIVE_LEVEL) begin
        active_level = data[0];
      end else if (idx == REG_TIMEOUT_TICKS) begin
        timeout_ticks = data[TicksW-1:0];
      end
    endfunction

    function bit phase_expired();
      phase_elapsed = phase_elapsed + TicksW'(1);
      return phase_elapsed >= timeout_ticks;
    endfunction

    function void close(logic [WidthW-1:0] width, outcome_e oc);
      result_t r;
      completed = completed + CountW'(1);
      if (longest < total_elapsed) longest = total_elapsed;
      phase = PH_IDLE;
      r.pulse_width = width;
      r.outcome = oc;
      r.measure_count = completed;
      r.measure_ticks = total_elapsed;
      r.max_measure_ticks = longest;
      measurements_due.push_back(r);
      if (oc != OUTCOME_VALID) timeouts++;
    endfunction

    // returns 0 for a request that the block ignores
    function bit note_request(logic cmd, logic pin);
      logic              active;
      logic [TicksW-1:0] units;
      active = (pin == active_level);
      if (cmd == CMD_START) begin
        if (phase != PH_IDLE) return 1'b0;
        phase = PH_LEAVE;
        phase_elapsed = '0;
        active_ticks = '0;
        total_elapsed = '0;
        return 1'b1;
      end
      if (phase == PH_IDLE) return 1'b0;
      total_elapsed = total_elapsed + CountW'(1);
      case (phase)
        PH_LEAVE: begin
          if (!active) begin
            phase = PH_WAIT;
            phase_elapsed = '0;
          end else if (phase_expired()) begin
            close(FULL_SCALE, OUTCOME_STUCK_ACTIVE);
          end
        end
        PH_WAIT: begin
          if (active) begin
            phase = PH_COUNT;
            phase_elapsed = '0;
            active_ticks = TicksW'(1);
          end else if (phase_expired()) begin
            close(MID_TIMEOUT_WIDTH, OUTCOME_STUCK_INACTIVE);
          end
        end
        default: begin
          if (!active) begin
            units = active_ticks / TicksW'(TICKS_PER_UNIT_DEF);
            close((units > TicksW'(WIDTH_MAX)) ? WIDTH_MAX : units[WidthW-1:0], OUTCOME_VALID);
          end else begin
            if (active_ticks != TICKS_MAX) active_ticks = active_ticks + TicksW'(1);
            if (phase_expired()) close(FULL_SCALE, OUTCOME_END_TIMEOUT);
          end
        end
      endcase
      return 1'b1;
    endfunction

    function void check_measurement(logic [WidthW-1:0] width, logic [1:0] oc,
                                    logic [CountW-1:0] count, logic [CountW-1:0] ticks,
                                    logic [CountW-1:0] max_ticks);
      result_t want;
      seen++;
      if (measurements_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected measurement: width %0d outcome %0d count %0d ticks %0d",
                   width, oc, count, ticks);
        end
        return;
      end
      want = measurements_due.pop_front();
      if (width !== want.pulse_width || outcome_e'(oc) !== want.outcome ||
          count !== want.measure_count || ticks !== want.measure_ticks ||
          max_ticks !== want.max_measure_ticks) begin
        errors++;
        if (errors <= 10) begin
          $display("measurement %0d: expected width %0d outcome %0d count %0d ticks %0d max %0d",
                   seen, want.pulse_width, want.outcome, want.measure_count,
                   want.measure_ticks, want.max_measure_ticks);
          $display("measurement %0d:      got width %0d outcome %0d count %0d ticks %0d max %0d",
                   seen, width, oc, count, ticks, max_ticks);
        end
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                cmd_i = CMD_TICK;
  logic                pin_level_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [WidthW-1:0]   pulse_width_o;
  logic [1:0]          outcome_o;
  logic [CountW-1:0]   measure_count_o;
  logic [CountW-1:0]   measure_ticks_o;
  logic [CountW-1:0]   max_measure_ticks_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  meter_scoreboard sb = new();
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;
  bit          long_hold = 1'b0;
  int unsigned requests_done = 0;
  int unsigned items_sent = 0;
  int unsigned settings_done = 0;
  int unsigned quiet_cycles = 0;

  pulse_width_meter_timeout u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .pin_level_i        (pin_level_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .pulse_width_o      (pulse_width_o),
    .outcome_o          (outcome_o),
    .measure_count_o    (measure_count_o),
    .measure_ticks_o    (measure_ticks_o),
    .max_measure_ticks_o(max_measure_ticks_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic send(input logic cmd, input logic pin);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    pin_level_i <= pin;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (sb.note_request(cmd, pin)) requests_done++;
  endtask

  task automatic send_ticks(input logic pin, input int unsigned n);
    repeat (n) send(CMD_TICK, pin);
  endtask

  task automatic send_pulse(input int unsigned lead, input int unsigned space,
                            input int unsigned width);
    send(CMD_START, 1'($urandom_range(0, 1)));
    send_ticks(sb.active_level, lead);
    send_ticks(~sb.active_level, space);
    send_ticks(sb.active_level, width);
    send_ticks(~sb.active_level, 1);
  endtask

  // random starts and pin levels, often breaking a measurement in progress
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 12);
    repeat (n) send($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
  endtask

  function automatic int unsigned draw_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 40);
    return $urandom_range(100, 400);
  endfunction

  // finish any measurement in progress, then wait for the output to drain
  task automatic settle();
    while (sb.phase != PH_IDLE) begin
      send(CMD_TICK, (sb.phase == PH_WAIT) ? sb.active_level : ~sb.active_level);
    end
    in_valid_i <= 1'b0;
    while (sb.measurements_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_setting(input logic level, input logic [TicksW-1:0] timeout,
                               input bit poke_spare);
    settle();
    if (poke_spare) begin
      cfg_write(REG_SPARE_A, CfgDataW'($urandom));
      cfg_write(REG_SPARE_B, CfgDataW'($urandom));
    end
    cfg_write(REG_ACTIVE_LEVEL, CfgDataW'(level));
    cfg_write(REG_TIMEOUT_TICKS, CfgDataW'(timeout));
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  initial begin : receiver
    int unsigned wait_n;
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold = 1'b0;
      end
      if ($urandom_range(0, 9) == 0) receiver_calm = ~receiver_calm;
      wait_n = receiver_calm ? 0 : $urandom_range(0, 3);
      if (wait_n != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o && !long_hold) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_measurement(pulse_width_o, outcome_o, measure_count_o, measure_ticks_o,
                           max_measure_ticks_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("[pulse_width_meter_timeout] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_budget;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: active high, long timeout
    send(CMD_TICK, 1'b1);   // ticks while idle are dropped
    send(CMD_TICK, 1'b0);
    send(CMD_START, 1'b0);
    send(CMD_START, 1'b1);  // start while busy
    send_ticks(1'b1, 2);
    send_ticks(1'b0, 1);
    send(CMD_START, 1'b0);
    send_ticks(1'b0, 1);
    send_ticks(1'b1, 9);
    send_ticks(1'b0, 1);

    // zero timeout with active low: every phase that the pin does not leave expires on its first counted tick
    apply_setting(1'b0, '0, 1'b1);
    send(CMD_START, 1'b1);
    send_ticks(1'b0, 1);
    send(CMD_START, 1'b1);
    send_ticks(1'b1, 2);
    send(CMD_START, 1'b0);
    send_ticks(1'b1, 1);
    send_ticks(1'b0, 2);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: apply_setting(1'b1, TICKS_MAX, 1'b0);
        1: apply_setting(1'b0, TicksW'(1), 1'b0);
        2: apply_setting(1'b1, TicksW'(3), 1'b0);
        3: apply_setting(1'b0, TicksW'($urandom_range(2, 20)), 1'b0);
        4: begin
          apply_setting(1'b1, TicksW'($urandom_range(2, 20)), 1'b0);
          long_hold = 1'b1;
        end
        5: apply_setting(1'b0, TICKS_MAX, 1'b0);
        6: apply_setting(1'($urandom_range(0, 1)), TicksW'($urandom_range(1, 40)), 1'b1);
        default: apply_setting(1'b1, TIMEOUT_RESET, 1'b0);
      endcase
      phase_budget = items_sent + RequestBudget / PhaseCount;
      while (items_sent < phase_budget) begin
        if ($urandom_range(0, 4) == 0) sender_calm = ~sender_calm;
        if ($urandom_range(0, 99) < 85) begin
          send_pulse(draw_len(), draw_len(), draw_len() + 1);
        end else begin
          send_noise();
        end
      end
    end

    settle();
    repeat (6) @(posedge clk_i);
    if (sb.measurements_due.size() != 0) sb.errors++;
    $display("covered %0d requests (%0d effective) and %0d measurements (%0d timed out)",
             items_sent, requests_done, sb.seen, sb.timeouts);
    $display("across %0d register settings, mismatches: %0d", settings_done, sb.errors);
    if (sb.errors == 0) begin
      $display("[pulse_width_meter_timeout] OK");
    end else begin
      $display("[pulse_width_meter_timeout] ERROR");
    end
    $finish;
  end

endmodule
